### rtl/core/tnb_pkg.sv
// ============================================================================
// tnb_pkg
// Shared types and constants for the triangle normal and bounds block.
// ============================================================================
`default_nettype none

package tnb_pkg;

    // Triangle request: three vertices, signed Q16.16.
    typedef struct packed {
        logic signed [31:0] v0_x;
        logic signed [31:0] v0_y;
        logic signed [31:0] v0_z;
        logic signed [31:0] v1_x;
        logic signed [31:0] v1_y;
        logic signed [31:0] v1_z;
        logic signed [31:0] v2_x;
        logic signed [31:0] v2_y;
        logic signed [31:0] v2_z;
    } t_tri_in;

    // Result: Q2.14 unit normal and padded Q16.16 box.
    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_tri_out;

    localparam int THIN_LIMIT = 66;     // 0.001 in Q16.16, rounded up
    localparam int PAD_LSB    = 33;     // 0.0005 in Q16.16
    localparam int Q14_ONE    = 16384;

    localparam int SQ_STAGES  = 16;     // two root bits per stage
    localparam int DV_STAGES  = 5;      // three quotient bits per stage
    localparam int NORM_LAT   = 7 + SQ_STAGES + DV_STAGES + 1;

endpackage

`default_nettype wire

### rtl/core/triangle_normal_and_bounds_top.sv
// Pipeline depth: NORM_LAT = 29 register stages.
// Throughput: one triangle per cycle; the whole pipeline advances together
// and holds while a finished result waits on a low i_out_ready.
// Latency comes mostly from the 16-stage square root and 5-stage divider chain.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits and holds
// o_in_ready low.
// ============================================================================
// triangle_normal_and_bounds_top
// Face normal (Q2.14) and padded axis-aligned bounds (Q16.16) per triangle.
// ============================================================================
`default_nettype none

module triangle_normal_and_bounds_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tnb_pkg::t_tri_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tnb_pkg::t_tri_out o_out_data
);
    import tnb_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] mn;
        logic [2:0][31:0] mx;
    } t_box;

    // Global advance: stall only when the final result is held.
    logic w_en;
    logic [NORM_LAT:1] r_vld;

    assign w_en       = !r_vld[NORM_LAT] || i_out_ready;
    assign o_in_ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NORM_LAT-1:1], i_in_valid};
        end
    end

    // Normal path
    logic signed [15:0] w_nx, w_ny, w_nz;

    tnb_normal u_normal (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_tri (i_in_data),
        .o_nx  (w_nx),
        .o_ny  (w_ny),
        .o_nz  (w_nz)
    );

    // Box path: min/max, then thin test and padding, then saturation.
    logic signed [31:0] w_v [3][3];

    assign w_v[0][0] = i_in_data.v0_x;
    assign w_v[0][1] = i_in_data.v0_y;
    assign w_v[0][2] = i_in_data.v0_z;
    assign w_v[1][0] = i_in_data.v1_x;
    assign w_v[1][1] = i_in_data.v1_y;
    assign w_v[1][2] = i_in_data.v1_z;
    assign w_v[2][0] = i_in_data.v2_x;
    assign w_v[2][1] = i_in_data.v2_y;
    assign w_v[2][2] = i_in_data.v2_z;

    logic signed [31:0] n_lo [3];
    logic signed [31:0] n_hi [3];
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_lo[i] = w_v[0][i];
            n_hi[i] = w_v[0][i];
            for (int k = 1; k < 3; k++) begin
                if (w_v[k][i] < n_lo[i]) begin
                    n_lo[i] = w_v[k][i];
                end
                if (w_v[k][i] > n_hi[i]) begin
                    n_hi[i] = w_v[k][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // Stage 2: thin axes get the pad; 33-bit sums so nothing wraps yet.
    logic signed [32:0] w_span [3];
    logic signed [32:0] r_plo  [3];
    logic signed [32:0] r_phi  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_span[i] = 33'(r_hi[i]) - 33'(r_lo[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_span[i] < 33'sd66) begin
                    r_plo[i] <= 33'(r_lo[i]) - 33'(PAD_LSB);
                    r_phi[i] <= 33'(r_hi[i]) + 33'(PAD_LSB);
                end else begin
                    r_plo[i] <= 33'(r_lo[i]);
                    r_phi[i] <= 33'(r_hi[i]);
                end
            end
        end
    end

    // Stage 3: saturate to Q16.16, then delay to line up with the normal.
    t_box n_box3;
    t_box r_bx [3:NORM_LAT];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_plo[i] < -33'sd2147483648) begin
                n_box3.mn[i] = 32'h8000_0000;
            end else begin
                n_box3.mn[i] = r_plo[i][31:0];
            end
            if (r_phi[i] > 33'sd2147483647) begin
                n_box3.mx[i] = 32'h7fff_ffff;
            end else begin
                n_box3.mx[i] = r_phi[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bx[3] <= n_box3;
            for (int k = 4; k <= NORM_LAT; k++) begin
                r_bx[k] <= r_bx[k-1];
            end
        end
    end

    // Result assembly
    assign o_out_valid          = r_vld[NORM_LAT];
    assign o_out_data.normal_x  = w_nx;
    assign o_out_data.normal_y  = w_ny;
    assign o_out_data.normal_z  = w_nz;
    assign o_out_data.box_min_x = r_bx[NORM_LAT].mn[0];
    assign o_out_data.box_min_y = r_bx[NORM_LAT].mn[1];
    assign o_out_data.box_min_z = r_bx[NORM_LAT].mn[2];
    assign o_out_data.box_max_x = r_bx[NORM_LAT].mx[0];
    assign o_out_data.box_max_y = r_bx[NORM_LAT].mx[1];
    assign o_out_data.box_max_z = r_bx[NORM_LAT].mx[2];

endmodule

`default_nettype wire

### rtl/core/tnb_normal.sv
// ============================================================================
// tnb_normal
// Pipelined unit normal: edges, cross product, block scaling, integer
// square root and rounded division. All stages share i_en.
// ============================================================================
`default_nettype none

module tnb_normal (
    input  logic              i_clk,
    input  logic              i_en,
    input  tnb_pkg::t_tri_in  i_tri,
    output logic signed [15:0] o_nx,
    output logic signed [15:0] o_ny,
    output logic signed [15:0] o_nz
);
    import tnb_pkg::*;

    typedef struct packed {
        logic [2:0][30:0] m;
        logic [2:0]       neg;
        logic             zero;
    } t_side;

    logic signed [31:0] w_v0 [3];
    logic signed [31:0] w_v1 [3];
    logic signed [31:0] w_v2 [3];

    assign w_v0[0] = i_tri.v0_x;
    assign w_v0[1] = i_tri.v0_y;
    assign w_v0[2] = i_tri.v0_z;
    assign w_v1[0] = i_tri.v1_x;
    assign w_v1[1] = i_tri.v1_y;
    assign w_v1[2] = i_tri.v1_z;
    assign w_v2[0] = i_tri.v2_x;
    assign w_v2[1] = i_tri.v2_y;
    assign w_v2[2] = i_tri.v2_z;

    // ---- stage 1: edges
    logic signed [32:0] r_e0 [3];
    logic signed [32:0] r_e1 [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e0[i] <= 33'(w_v1[i]) - 33'(w_v0[i]);
                r_e1[i] <= 33'(w_v2[i]) - 33'(w_v1[i]);
            end
        end
    end

    // ---- stage 2: six products
    logic signed [65:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_e1[1] * r_e0[2];
            r_p[1] <= r_e1[2] * r_e0[1];
            r_p[2] <= r_e1[2] * r_e0[0];
            r_p[3] <= r_e1[0] * r_e0[2];
            r_p[4] <= r_e1[0] * r_e0[1];
            r_p[5] <= r_e1[1] * r_e0[0];
        end
    end

    // ---- stage 3: cross components as sign and magnitude
    logic signed [66:0] w_c [3];
    logic [64:0]        r3_mag [3];
    logic [2:0]         r3_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = 67'(r_p[2*i]) - 67'(r_p[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r3_neg[i] <= w_c[i][66];
                r3_mag[i] <= w_c[i][66] ? 65'(-w_c[i]) : 65'(w_c[i]);
            end
        end
    end

    // ---- stage 4: bit length of the largest magnitude
    logic [64:0] w_or;
    logic [6:0]  w_bl;
    logic [64:0] r4_mag [3];
    logic [2:0]  r4_neg;
    logic [6:0]  r4_bl;

    always_comb begin
        w_or = r3_mag[0] | r3_mag[1] | r3_mag[2];
        w_bl = '0;
        for (int i = 0; i < 65; i++) begin
            if (w_or[i]) begin
                w_bl = 7'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_bl  <= w_bl;
        end
    end

    // ---- stage 5: block scaling to [2^30, 2^31)
    t_side       n5_sd;
    t_side       r5_sd;
    logic [64:0] w_sh;

    always_comb begin
        n5_sd.neg  = r4_neg;
        n5_sd.zero = (r4_bl == 7'd0);
        for (int i = 0; i < 3; i++) begin
            if (r4_bl > 7'd31) begin
                w_sh = r4_mag[i] >> (r4_bl - 7'd31);
            end else begin
                w_sh = r4_mag[i] << (7'd31 - r4_bl);
            end
            n5_sd.m[i] = w_sh[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_sd <= n5_sd;
        end
    end

    // ---- stage 6: squares
    logic [61:0] r6_sq [3];
    t_side       r6_sd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= 62'(r5_sd.m[i]) * 62'(r5_sd.m[i]);
            end
            r6_sd <= r5_sd;
        end
    end

    // ---- stage 7: sum of squares
    logic [63:0] r7_sum;
    t_side       r7_sd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_sum <= 64'(r6_sq[0]) + 64'(r6_sq[1]) + 64'(r6_sq[2]);
            r7_sd  <= r6_sd;
        end
    end

    // ---- square root stages, two root bits each
    logic [34:0] w_sq_rem  [SQ_STAGES];
    logic [31:0] w_sq_root [SQ_STAGES];
    logic [63:0] w_sq_x    [SQ_STAGES];
    t_side       w_sq_sd   [SQ_STAGES];
    logic [34:0] n_sq_rem  [SQ_STAGES];
    logic [31:0] n_sq_root [SQ_STAGES];
    logic [63:0] n_sq_x    [SQ_STAGES];
    logic [34:0] r_sq_rem  [SQ_STAGES];
    logic [31:0] r_sq_root [SQ_STAGES];
    logic [63:0] r_sq_x    [SQ_STAGES];
    t_side       r_sq_sd   [SQ_STAGES];

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_x[0]    = r7_sum;
    assign w_sq_sd[0]   = r7_sd;

    genvar gk;
    generate
        for (gk = 1; gk < SQ_STAGES; gk++) begin : g_sq_link
            assign w_sq_rem[gk]  = r_sq_rem[gk-1];
            assign w_sq_root[gk] = r_sq_root[gk-1];
            assign w_sq_x[gk]    = r_sq_x[gk-1];
            assign w_sq_sd[gk]   = r_sq_sd[gk-1];
        end

        for (gk = 0; gk < SQ_STAGES; gk++) begin : g_sq
            always_comb begin : c_step
                logic [34:0] rem;
                logic [31:0] root;
                logic [63:0] x;
                logic [34:0] trial;
                rem  = w_sq_rem[gk];
                root = w_sq_root[gk];
                x    = w_sq_x[gk];
                for (int j = 0; j < 2; j++) begin
                    rem   = {rem[32:0], x[63:62]};
                    x     = {x[61:0], 2'b00};
                    trial = {1'b0, root, 2'b01};
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[30:0], 1'b1};
                    end else begin
                        root = {root[30:0], 1'b0};
                    end
                end
                n_sq_rem[gk]  = rem;
                n_sq_root[gk] = root;
                n_sq_x[gk]    = x;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_rem[gk]  <= n_sq_rem[gk];
                    r_sq_root[gk] <= n_sq_root[gk];
                    r_sq_x[gk]    <= n_sq_x[gk];
                    r_sq_sd[gk]   <= w_sq_sd[gk];
                end
            end
        end
    endgenerate

    // ---- division stages: q = (m * 2^14 + L/2) / L, three bits each
    logic [2:0][32:0] w_dv_rem [DV_STAGES];
    logic [2:0][14:0] w_dv_nlo [DV_STAGES];
    logic [2:0][14:0] w_dv_q   [DV_STAGES];
    logic [31:0]      w_dv_len [DV_STAGES];
    t_side            w_dv_sd  [DV_STAGES];
    logic [2:0][32:0] n_dv_rem [DV_STAGES];
    logic [2:0][14:0] n_dv_nlo [DV_STAGES];
    logic [2:0][14:0] n_dv_q   [DV_STAGES];
    logic [2:0][32:0] r_dv_rem [DV_STAGES];
    logic [2:0][14:0] r_dv_nlo [DV_STAGES];
    logic [2:0][14:0] r_dv_q   [DV_STAGES];
    logic [31:0]      r_dv_len [DV_STAGES];
    t_side            r_dv_sd  [DV_STAGES];

    logic [45:0] w_num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {1'b0, r_sq_sd[SQ_STAGES-1].m[i], 14'b0}
                     + 46'(r_sq_root[SQ_STAGES-1] >> 1);
            w_dv_rem[0][i] = {2'b00, w_num[i][45:15]};
            w_dv_nlo[0][i] = w_num[i][14:0];
            w_dv_q[0][i]   = '0;
        end
    end

    assign w_dv_len[0] = r_sq_root[SQ_STAGES-1];
    assign w_dv_sd[0]  = r_sq_sd[SQ_STAGES-1];

    generate
        for (gk = 1; gk < DV_STAGES; gk++) begin : g_dv_link
            assign w_dv_rem[gk] = r_dv_rem[gk-1];
            assign w_dv_nlo[gk] = r_dv_nlo[gk-1];
            assign w_dv_q[gk]   = r_dv_q[gk-1];
            assign w_dv_len[gk] = r_dv_len[gk-1];
            assign w_dv_sd[gk]  = r_dv_sd[gk-1];
        end

        for (gk = 0; gk < DV_STAGES; gk++) begin : g_dv
            always_comb begin : c_step
                logic [32:0] rem;
                logic [14:0] nlo;
                logic [14:0] q;
                for (int i = 0; i < 3; i++) begin
                    rem = w_dv_rem[gk][i];
                    nlo = w_dv_nlo[gk][i];
                    q   = w_dv_q[gk][i];
                    for (int j = 0; j < 3; j++) begin
                        rem = {rem[31:0], nlo[14]};
                        nlo = {nlo[13:0], 1'b0};
                        if (rem >= {1'b0, w_dv_len[gk]}) begin
                            rem = rem - {1'b0, w_dv_len[gk]};
                            q   = {q[13:0], 1'b1};
                        end else begin
                            q   = {q[13:0], 1'b0};
                        end
                    end
                    n_dv_rem[gk][i] = rem;
                    n_dv_nlo[gk][i] = nlo;
                    n_dv_q[gk][i]   = q;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_rem[gk] <= n_dv_rem[gk];
                    r_dv_nlo[gk] <= n_dv_nlo[gk];
                    r_dv_q[gk]   <= n_dv_q[gk];
                    r_dv_len[gk] <= w_dv_len[gk];
                    r_dv_sd[gk]  <= w_dv_sd[gk];
                end
            end
        end
    endgenerate

    // ---- output stage: clamp, sign, degenerate case
    logic [15:0]        w_qc [3];
    logic signed [15:0] n_n  [3];
    logic signed [15:0] r_n  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_qc[i] = {1'b0, r_dv_q[DV_STAGES-1][i]};
            if (w_qc[i] > 16'(Q14_ONE)) begin
                w_qc[i] = 16'(Q14_ONE);
            end
            if (r_dv_sd[DV_STAGES-1].zero) begin
                n_n[i] = '0;
            end else if (r_dv_sd[DV_STAGES-1].neg[i]) begin
                n_n[i] = -$signed(w_qc[i]);
            end else begin
                n_n[i] = $signed(w_qc[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n;
        end
    end

    assign o_nx = r_n[0];
    assign o_ny = r_n[1];
    assign o_nz = r_n[2];

endmodule

`default_nettype wire
